FILE: design/rto_pkg.sv
// ----------------------------------------------------------------------------
// rto_pkg
// shared types, constants and helper functions of the ramp/triangle oscillator
// ----------------------------------------------------------------------------
package rto_pkg;

  localparam int LevelW  = 32;
  localparam int AmpW    = 31;
  localparam int CtW     = 24;
  localparam int ModeW   = 2;
  localparam int LimitW  = 16;
  localparam int TdW     = 16;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 32;
  localparam int ProdW   = TdW + AmpW;        // product and quotient width
  localparam int SumW    = ProdW + 2;         // signed sum of level and delta
  localparam int DivSteps = ProdW;
  localparam int DivCntW = $clog2(DivSteps);

  localparam logic [LevelW-1:0] LevelMax = {1'b0, {(LevelW-1){1'b1}}};
  localparam logic [LimitW-1:0] EdgesMax = {LimitW{1'b1}};

  // mode codes
  localparam logic [ModeW-1:0] ModeSawUp   = 2'd0;
  localparam logic [ModeW-1:0] ModeSawDown = 2'd1;
  localparam logic [ModeW-1:0] ModeTriUp   = 2'd2;
  localparam logic [ModeW-1:0] ModeTriDown = 2'd3;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegOffset      = 3'd0;
  localparam logic [CfgIdxW-1:0] RegAmplitude   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegCycleTime   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegMode        = 3'd3;
  localparam logic [CfgIdxW-1:0] RegCycleLimit  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegManualStart = 3'd5;

  // reset values
  localparam logic [LevelW-1:0] OffsetRst    = '0;
  localparam logic [AmpW-1:0]   AmplitudeRst = AmpW'(65536);
  localparam logic [CtW-1:0]    CycleTimeRst = CtW'(1000000);

  typedef struct packed {
    logic restart;     // reinit and trigger
    logic load_mul;    // register product into the divider
    logic div_step;    // one quotient bit
    logic load_sum;    // level +/- delta
    logic apply_edge;  // wrap, reflect or clamp and update state
    logic load_out;    // present the result word
  } rto_cmd_t;

  typedef struct packed {
    logic running;
    logic out_busy;
  } rto_status_t;

  // upper edge, saturated to the largest level
  function automatic logic signed [LevelW-1:0] hi_edge(
    input logic signed [LevelW-1:0] offs,
    input logic [AmpW-1:0]          amp
  );
    logic signed [LevelW:0] s;
    s = $signed({offs[LevelW-1], offs}) + $signed({2'b00, amp});
    if (s > $signed({1'b0, LevelMax})) begin
      return $signed(LevelMax);
    end
    return s[LevelW-1:0];
  endfunction

  function automatic logic starts_up(input logic [ModeW-1:0] m);
    return (m == ModeSawUp) || (m == ModeTriUp);
  endfunction

endpackage

FILE: design/ramp_triangle_oscillator.sv
// ----------------------------------------------------------------------------
// ramp_triangle_oscillator
// sawtooth / triangle parameter oscillator in Q16.16
// ----------------------------------------------------------------------------
// in_ channel: one word per tick (in_tuser = 0, in_tdata = elapsed time) or
// restart (in_tuser = 1). every word yields one out_ word with the level and
// the finished/running flags.
// cfg_ channel: register writes (offset, amplitude, cycle_time, mode,
// cycle_limit, manual_start by index 0..5), taken while the block is idle;
// each write restarts the sweep at its starting edge.
// a tick that advances the level passes from accept to out_tvalid through
// one multiply, 47 steps of the bit-serial divider that forms
// time*amplitude/cycle_time, one add, one edge step and one output load.
// restarts and ticks that do not advance go straight to the output load.
// one word is in work at a time; in_tready is high whenever the sequencer
// is idle, so a new word is taken only after the last one's result is loaded.
// the output register holds a result until out_tready; a new word is
// accepted meanwhile and waits to load until the old result is taken.
// reset loads the register defaults and puts the level at the lower edge.
// ----------------------------------------------------------------------------
module ramp_triangle_oscillator
  import rto_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  // config write
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  // input stream
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [TdW-1:0]      in_tdata,    // [15:0] time_delta
  input  logic                in_tuser,    // [0] action
  // result stream
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [LevelW-1:0]   out_tdata,   // [31:0] level
  output logic [1:0]          out_tuser    // [0] finished, [1] running
);

  rto_cmd_t    cmd;
  rto_status_t status;
  logic        idle;
  logic        in_fire;
  logic        cfg_fire;
  logic        fin, run;

  assign cfg_ready = idle;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign in_tready = idle;
  assign in_fire   = in_tvalid && in_tready;

  rto_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_action (in_tuser),
    .status    (status),
    .idle      (idle),
    .cmd       (cmd)
  );

  rto_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_fire     (cfg_fire),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_fire      (in_fire),
    .in_td        (in_tdata),
    .cmd          (cmd),
    .status       (status),
    .out_tready   (out_tready),
    .out_tvalid   (out_tvalid),
    .out_level    (out_tdata),
    .out_finished (fin),
    .out_running  (run)
  );

  assign out_tuser = {run, fin};

endmodule

FILE: design/rto_ctrl.sv
// ----------------------------------------------------------------------------
// rto_ctrl
// sequencer: accepts items, loads the output and steps the datapath through multiply, serial
// divide, add and edge handling
// ----------------------------------------------------------------------------
module rto_ctrl
  import rto_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_fire,
  input  logic        in_action,
  input  rto_status_t status,
  output logic        idle,
  output rto_cmd_t    cmd
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMul  = 3'd1;
  localparam logic [2:0] StDiv  = 3'd2;
  localparam logic [2:0] StAdd  = 3'd3;
  localparam logic [2:0] StEdge = 3'd4;
  localparam logic [2:0] StDone = 3'd5;

  logic [2:0]         state_r, state_nxt;
  logic [DivCntW-1:0] cnt_r, cnt_nxt;

  assign idle = (state_r == StIdle);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r)
      StIdle: begin
        if (in_fire) begin
          if (in_action) begin
            cmd.restart = 1'b1;
            state_nxt   = StDone;
          end else if (status.running) begin
            state_nxt = StMul;
          end else begin
            state_nxt = StDone;
          end
        end
      end
      StMul: begin
        cmd.load_mul = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = StDiv;
      end
      StDiv: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == DivCntW'(DivSteps - 1)) begin
          state_nxt = StAdd;
        end
      end
      StAdd: begin
        cmd.load_sum = 1'b1;
        state_nxt    = StEdge;
      end
      StEdge: begin
        cmd.apply_edge = 1'b1;
        state_nxt      = StDone;
      end
      StDone: begin
        if (!status.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = StIdle;
        end
      end
      default: state_nxt = StIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= StIdle;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

FILE: design/rto_datapath.sv
// ----------------------------------------------------------------------------
// rto_datapath
// config registers, oscillator state, multiplier, serial divider, edge logic
// and the output register
// ----------------------------------------------------------------------------
module rto_datapath
  import rto_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_fire,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  input  logic                in_fire,
  input  logic [TdW-1:0]      in_td,
  input  rto_cmd_t            cmd,
  output rto_status_t         status,
  input  logic                out_tready,
  output logic                out_tvalid,
  output logic [LevelW-1:0]   out_level,
  output logic                out_finished,
  output logic                out_running
);

  // configuration
  logic signed [LevelW-1:0] offset_r, offset_nxt;
  logic [AmpW-1:0]          amplitude_r, amplitude_nxt;
  logic [CtW-1:0]           cycle_time_r, cycle_time_nxt;
  logic [ModeW-1:0]         mode_r, mode_nxt;
  logic [LimitW-1:0]        cycle_limit_r, cycle_limit_nxt;
  logic                     manual_start_r, manual_start_nxt;
  logic                     cfg_hit;

  // oscillator state
  logic signed [LevelW-1:0] level_r, level_nxt;
  logic                     going_up_r, going_up_nxt;
  logic [LimitW-1:0]        edges_r, edges_nxt;
  logic                     triggered_r, triggered_nxt;

  // arithmetic
  logic [TdW-1:0]           td_r;
  logic [ProdW-1:0]         quo_r;
  logic [CtW-1:0]           rem_r;
  logic [CtW-1:0]           divisor;
  logic [CtW:0]             trial;
  logic [CtW:0]             trial_sub;
  logic signed [SumW-1:0]   sum_r;
  logic                     up_r;
  logic                     up_now;

  // edge handling
  logic signed [LevelW-1:0] lo, hi;
  logic [LevelW-1:0]        span;
  logic signed [SumW-1:0]   lo_x, hi_x;
  logic                     cross_up, cross_dn;
  logic signed [SumW-1:0]   over_full;
  logic [LevelW-1:0]        over;
  logic [LimitW-1:0]        edges_inc;
  logic                     go_on;
  logic                     finished, running;

  // output register
  logic                     out_valid_r;
  logic [LevelW-1:0]        out_level_r;
  logic                     out_finished_r, out_running_r;

  // ---- configuration writes ----
  always_comb begin
    offset_nxt       = offset_r;
    amplitude_nxt    = amplitude_r;
    cycle_time_nxt   = cycle_time_r;
    mode_nxt         = mode_r;
    cycle_limit_nxt  = cycle_limit_r;
    manual_start_nxt = manual_start_r;
    cfg_hit          = 1'b0;
    if (cfg_fire) begin
      cfg_hit = 1'b1;
      unique case (cfg_index)
        RegOffset:      offset_nxt       = $signed(cfg_data[LevelW-1:0]);
        RegAmplitude:   amplitude_nxt    = cfg_data[AmpW-1:0];
        RegCycleTime:   cycle_time_nxt   = cfg_data[CtW-1:0];
        RegMode:        mode_nxt         = cfg_data[ModeW-1:0];
        RegCycleLimit:  cycle_limit_nxt  = cfg_data[LimitW-1:0];
        RegManualStart: manual_start_nxt = cfg_data[0];
        default:        cfg_hit          = 1'b0;
      endcase
    end
  end

  // ---- status ----
  assign finished = (cycle_limit_r != '0) && (edges_r >= cycle_limit_r);
  assign running  = (!manual_start_r || triggered_r) && !finished;
  assign status.running  = running;
  assign status.out_busy = out_valid_r && !out_tready;

  // ---- divider ----
  assign divisor   = (cycle_time_r == '0) ? CtW'(1) : cycle_time_r;
  assign trial     = {rem_r, quo_r[ProdW-1]};
  assign trial_sub = trial - {1'b0, divisor};

  // ---- edges ----
  assign lo   = offset_r;
  assign hi   = hi_edge(offset_r, amplitude_r);
  assign span = LevelW'(hi - lo);
  assign lo_x = SumW'(lo);
  assign hi_x = SumW'(hi);

  assign up_now = (mode_r == ModeSawUp) ? 1'b1 :
                  (mode_r == ModeSawDown) ? 1'b0 : going_up_r;

  assign cross_up  = up_r && (sum_r > hi_x);
  assign cross_dn  = !up_r && (sum_r < lo_x);
  assign over_full = up_r ? (sum_r - hi_x) : (lo_x - sum_r);
  // remainder past the edge saturates to the span
  assign over = (over_full > $signed({{(SumW-LevelW){1'b0}}, span})) ?
                span : over_full[LevelW-1:0];
  assign edges_inc = (edges_r == EdgesMax) ? edges_r : edges_r + 1'b1;
  assign go_on     = (cycle_limit_r == '0) || (edges_inc < cycle_limit_r);

  always_comb begin
    level_nxt     = level_r;
    going_up_nxt  = going_up_r;
    edges_nxt     = edges_r;
    triggered_nxt = triggered_r;
    if (cfg_hit) begin
      level_nxt    = starts_up(mode_nxt) ? offset_nxt :
                     hi_edge(offset_nxt, amplitude_nxt);
      going_up_nxt = starts_up(mode_nxt);
      edges_nxt    = '0;
    end else if (cmd.restart) begin
      level_nxt     = starts_up(mode_r) ? lo : hi;
      going_up_nxt  = starts_up(mode_r);
      edges_nxt     = '0;
      triggered_nxt = 1'b1;
    end else if (cmd.apply_edge) begin
      level_nxt = sum_r[LevelW-1:0];
      if (cross_up) begin
        edges_nxt = edges_inc;
        if (!go_on) begin
          level_nxt = hi;
        end else if (mode_r == ModeSawUp) begin
          level_nxt = lo + $signed(over);
        end else begin
          level_nxt    = hi - $signed(over);
          going_up_nxt = 1'b0;
        end
      end else if (cross_dn) begin
        edges_nxt = edges_inc;
        if (!go_on) begin
          level_nxt = lo;
        end else if (mode_r == ModeSawDown) begin
          level_nxt = hi - $signed(over);
        end else begin
          level_nxt    = lo + $signed(over);
          going_up_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r       <= OffsetRst;
      amplitude_r    <= AmplitudeRst;
      cycle_time_r   <= CycleTimeRst;
      mode_r         <= ModeSawUp;
      cycle_limit_r  <= '0;
      manual_start_r <= 1'b0;
      level_r        <= OffsetRst;
      going_up_r     <= 1'b1;
      edges_r        <= '0;
      triggered_r    <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      offset_r       <= offset_nxt;
      amplitude_r    <= amplitude_nxt;
      cycle_time_r   <= cycle_time_nxt;
      mode_r         <= mode_nxt;
      cycle_limit_r  <= cycle_limit_nxt;
      manual_start_r <= manual_start_nxt;
      level_r        <= level_nxt;
      going_up_r     <= going_up_nxt;
      edges_r        <= edges_nxt;
      triggered_r    <= triggered_nxt;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      td_r <= in_td;
    end
    if (cmd.load_mul) begin
      quo_r <= ProdW'(td_r) * ProdW'(amplitude_r);
      rem_r <= '0;
    end else if (cmd.div_step) begin
      if (!trial_sub[CtW]) begin
        rem_r <= trial_sub[CtW-1:0];
        quo_r <= {quo_r[ProdW-2:0], 1'b1};
      end else begin
        rem_r <= trial[CtW-1:0];
        quo_r <= {quo_r[ProdW-2:0], 1'b0};
      end
    end
    if (cmd.load_sum) begin
      up_r  <= up_now;
      sum_r <= up_now ? (SumW'(level_r) + $signed({2'b00, quo_r})) :
                        (SumW'(level_r) - $signed({2'b00, quo_r}));
    end
    if (cmd.load_out) begin
      out_level_r    <= level_r;
      out_finished_r <= finished;
      out_running_r  <= running;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_level    = out_level_r;
  assign out_finished = out_finished_r;
  assign out_running  = out_running_r;

endmodule
